[design/ntpc_pkg.sv]
// ntpc_pkg: shared sizes, codes, row types and name compare helpers
// for the name table prefix completion unit. No dependencies.
package ntpc_pkg;

    localparam int FILE_ENTRIES = 64;
    localparam int CMD_ENTRIES  = 128;
    localparam int NAME_CHARS   = 12;

    localparam int FIDX_W = $clog2(FILE_ENTRIES);
    localparam int CIDX_W = $clog2(CMD_ENTRIES);
    localparam int FCNT_W = $clog2(FILE_ENTRIES + 1);
    localparam int CCNT_W = $clog2(CMD_ENTRIES + 1);
    localparam int PTR_W  = (FCNT_W > CCNT_W) ? FCNT_W : CCNT_W;
    localparam int LEN_W  = $clog2(NAME_CHARS + 1);

    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] BELL_CHAR  = 8'h07;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] BSLASH     = 8'h5C;

    typedef logic [NAME_CHARS-1:0][7:0] t_name;

    typedef struct packed {
        t_name            chars;
        logic [LEN_W-1:0] len;
        logic             dir;
    } t_row;

    typedef enum logic [2:0] {
        MODE_CLR   = 3'd0,
        MODE_FCHAR = 3'd1,
        MODE_CCHAR = 3'd2,
        MODE_QUERY = 3'd3,
        MODE_PCHAR = 3'd4,
        MODE_TAB   = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BCLR,
        OP_ISTART,
        OP_IRD,
        OP_ISHIFT,
        OP_IPUT,
        OP_CSTART,
        OP_CRD,
        OP_CNEXT,
        OP_CPUT,
        OP_SRD,
        OP_SEV,
        OP_RETRY,
        OP_EMIT,
        OP_BELL
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FCHK,
        ST_IRD,
        ST_ICMP,
        ST_CCHK,
        ST_CRD,
        ST_CCMP,
        ST_SRD,
        ST_SEV,
        ST_ROOM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic fin_ok;
        logic cmd_ok;
        logic ptr_zero;
        logic ptr_at_cent;
        logic row_gt;
        logic row_eq;
        logic scan_end;
        logic hit_now;
        logic can_retry;
        logic can_fallback;
        logic no_room;
        logic emit_last;
    } t_stat;

    function automatic logic [7:0] fold_up(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - CASE_BIT : c;
    endfunction

    // a > b under folded order, shorter prefix first
    function automatic logic name_gt(input t_name a, input logic [LEN_W-1:0] la,
                                     input t_name b, input logic [LEN_W-1:0] lb);
        logic [LEN_W-1:0] n;
        logic             res;
        logic             found;
        n     = (la < lb) ? la : lb;
        res   = la > lb;
        found = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (!found && i < int'(n) && fold_up(a[i]) != fold_up(b[i])) begin
                res   = fold_up(a[i]) > fold_up(b[i]);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic name_eq(input t_name a, input logic [LEN_W-1:0] la,
                                     input t_name b, input logic [LEN_W-1:0] lb);
        logic eq;
        eq = (la == lb);
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (i < int'(la) && fold_up(a[i]) != fold_up(b[i])) begin
                eq = 1'b0;
            end
        end
        return eq;
    endfunction

    function automatic logic pfx_fit(input t_name e, input logic [LEN_W-1:0] le,
                                     input t_name p, input logic [LEN_W-1:0] lp);
        logic ok;
        ok = (le >= lp);
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (i < int'(lp) && fold_up(e[i]) != fold_up(p[i])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

[design/ntpc_dp.sv]
// ntpc_dp: datapath of the completion unit: name tables in RAM, build and
// prefix buffers, scan counters, result register. Depends on ntpc_pkg.
module ntpc_dp import ntpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_symbol,
    input  logic       i_is_directory,
    input  logic       i_first_word,
    input  logic [6:0] i_room,
    output t_stat      o_stat,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_out_symbol,
    output logic       o_final_res
);

    t_row file_mem [FILE_ENTRIES];
    t_row cmd_mem  [CMD_ENTRIES];

    t_row              r_frow;
    t_row              r_crow;
    t_name             r_build;
    logic [LEN_W-1:0]  r_blen;
    t_name             r_pfx;
    logic [LEN_W-1:0]  r_plen;
    logic              r_fw;
    logic              r_sess;
    logic              r_ucmd;
    logic [7:0]        r_cidx;
    logic [7:0]        r_cnt;
    logic [FCNT_W-1:0] r_fent;
    logic [CCNT_W-1:0] r_cent;
    logic [PTR_W-1:0]  r_ptr;
    logic              r_dir;
    logic [6:0]        r_room;
    t_name             r_hname;
    logic [LEN_W-1:0]  r_hlen;
    logic              r_hsuf;
    logic [7:0]        r_hsch;
    logic [LEN_W-1:0]  r_eidx;
    logic              r_ovalid;
    logic              r_okind;
    logic [7:0]        r_osym;
    logic              r_ofin;

    t_row             s_row;
    logic [PTR_W-1:0] s_size;
    logic [PTR_W-1:0] s_ptr_m1;
    logic [7:0]       s_char;
    logic             s_fits;
    logic [LEN_W:0]   s_nres;
    logic [7:0]       s_esym;
    t_row             s_brow;

    assign s_row    = r_ucmd ? r_crow : r_frow;
    assign s_size   = r_ucmd ? PTR_W'(r_cent) : PTR_W'(r_fent);
    assign s_ptr_m1 = r_ptr - PTR_W'(1);
    assign s_fits   = pfx_fit(s_row.chars, s_row.len, r_pfx, r_plen);
    assign s_nres   = {1'b0, r_hlen} + (LEN_W+1)'(r_hsuf);
    assign s_esym   = (r_eidx < r_hlen) ? r_hname[r_eidx] : r_hsch;
    assign s_brow   = '{chars: r_build, len: r_blen, dir: r_dir};

    always_comb begin
        s_char = i_symbol;
        if (i_mode == MODE_FCHAR) begin
            if (i_symbol >= 8'h41 && i_symbol <= 8'h5A) begin
                s_char = i_symbol + CASE_BIT;
            end
        end else begin
            s_char = fold_up(i_symbol);
        end
    end

    always_comb begin
        o_stat.fin_ok       = (r_blen != '0) && (r_build[0] != DOT_CHAR)
                              && (r_fent < FCNT_W'(FILE_ENTRIES));
        o_stat.cmd_ok       = (r_blen != '0) && (r_cent < CCNT_W'(CMD_ENTRIES));
        o_stat.ptr_zero     = (r_ptr == '0);
        o_stat.ptr_at_cent  = (r_ptr == PTR_W'(r_cent));
        o_stat.row_gt       = name_gt(r_frow.chars, r_frow.len, r_build, r_blen);
        o_stat.row_eq       = name_eq(r_crow.chars, r_crow.len, r_build, r_blen);
        o_stat.scan_end     = (r_ptr == s_size);
        o_stat.hit_now      = s_fits && (r_cnt == r_cidx);
        o_stat.can_retry    = (r_cidx != '0);
        o_stat.can_fallback = !r_ucmd && r_fw && (r_plen != '0);
        o_stat.no_room      = 7'(s_nres) > r_room;
        o_stat.emit_last    = ({1'b0, r_eidx} + (LEN_W+1)'(1)) == s_nres;
    end

    // table RAMs
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ISHIFT: file_mem[r_ptr[FIDX_W-1:0]] <= r_frow;
            OP_IPUT:   file_mem[r_ptr[FIDX_W-1:0]] <= s_brow;
            OP_CPUT:   cmd_mem[r_cent[CIDX_W-1:0]] <= s_brow;
            default: ;
        endcase
        if (i_op == OP_IRD) begin
            r_frow <= file_mem[s_ptr_m1[FIDX_W-1:0]];
        end else if (i_op == OP_SRD && !r_ucmd) begin
            r_frow <= file_mem[r_ptr[FIDX_W-1:0]];
        end
        if (i_op == OP_CRD || (i_op == OP_SRD && r_ucmd)) begin
            r_crow <= cmd_mem[r_ptr[CIDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen   <= '0;
            r_plen   <= '0;
            r_fw     <= 1'b0;
            r_sess   <= 1'b0;
            r_ucmd   <= 1'b0;
            r_cidx   <= '0;
            r_fent   <= '0;
            r_cent   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (i_op)
                OP_LOAD: begin
                    case (i_mode)
                        MODE_CLR: r_fent <= '0;
                        MODE_FCHAR, MODE_CCHAR: begin
                            if (r_blen < LEN_W'(NAME_CHARS)) begin
                                r_build[r_blen] <= s_char;
                                r_blen          <= r_blen + LEN_W'(1);
                            end
                            r_dir <= i_is_directory;
                        end
                        MODE_QUERY: begin
                            r_plen <= '0;
                            r_fw   <= i_first_word;
                            r_sess <= 1'b0;
                            r_ucmd <= 1'b0;
                            r_cidx <= '0;
                        end
                        MODE_PCHAR: begin
                            if (r_plen < LEN_W'(NAME_CHARS)) begin
                                r_pfx[r_plen] <= i_symbol;
                                r_plen        <= r_plen + LEN_W'(1);
                            end
                            r_sess <= 1'b0;
                        end
                        MODE_TAB: begin
                            if (!r_sess) begin
                                r_ucmd <= 1'b0;
                                r_cidx <= '0;
                            end
                            r_ptr  <= '0;
                            r_cnt  <= '0;
                            r_room <= i_room;
                        end
                        default: ;
                    endcase
                end
                OP_BCLR:   r_blen <= '0;
                OP_ISTART: r_ptr <= PTR_W'(r_fent);
                OP_ISHIFT: r_ptr <= s_ptr_m1;
                OP_IPUT: begin
                    r_fent <= r_fent + FCNT_W'(1);
                    r_blen <= '0;
                end
                OP_CSTART: r_ptr <= '0;
                OP_CNEXT:  r_ptr <= r_ptr + PTR_W'(1);
                OP_CPUT: begin
                    r_cent <= r_cent + CCNT_W'(1);
                    r_blen <= '0;
                end
                OP_SEV: begin
                    r_ptr <= r_ptr + PTR_W'(1);
                    if (s_fits) begin
                        if (r_cnt == r_cidx) begin
                            r_hname <= s_row.chars;
                            r_hlen  <= s_row.len;
                            r_hsuf  <= r_ucmd | s_row.dir;
                            r_hsch  <= r_ucmd ? SPACE_CHAR : BSLASH;
                            r_eidx  <= '0;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                end
                OP_RETRY: begin
                    if (r_cidx == '0) begin
                        r_ucmd <= 1'b1;
                    end
                    r_cidx <= '0;
                    r_ptr  <= '0;
                    r_cnt  <= '0;
                end
                OP_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_okind  <= 1'b0;
                    r_osym   <= s_esym;
                    r_ofin   <= o_stat.emit_last;
                    r_eidx   <= r_eidx + LEN_W'(1);
                    if (o_stat.emit_last) begin
                        r_sess <= 1'b1;
                        r_cidx <= r_cidx + 8'd1;
                    end
                end
                OP_BELL: begin
                    r_ovalid <= 1'b1;
                    r_okind  <= 1'b1;
                    r_osym   <= BELL_CHAR;
                    r_ofin   <= 1'b1;
                    r_sess   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_kind       = r_okind;
    assign o_out_symbol = r_osym;
    assign o_final_res  = r_ofin;

`ifndef SYNTH
    a_bell_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_okind |-> r_ofin)
        else $error("bell beat not marked final");
    a_bell_ends_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_BELL |=> !r_sess)
        else $error("session survives a bell");
    a_file_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fent <= FCNT_W'(FILE_ENTRIES))
        else $error("file table count overflow");
    a_cmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cent <= CCNT_W'(CMD_ENTRIES))
        else $error("command table count overflow");
`endif

endmodule

[design/ntpc_ctrl.sv]
// ntpc_ctrl: sequencer for loading, sorted insertion, duplicate check,
// match scan and result emission. Depends on ntpc_pkg.
module ntpc_ctrl import ntpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_mode,
    input  logic       i_last,
    input  t_stat      i_stat,
    output t_op        o_op,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_op = OP_LOAD;
                    if (i_mode == MODE_FCHAR && i_last) begin
                        n_state = ST_FCHK;
                    end else if (i_mode == MODE_CCHAR && i_last) begin
                        n_state = ST_CCHK;
                    end else if (i_mode == MODE_TAB) begin
                        n_state = ST_SRD;
                    end
                end
            end
            ST_FCHK: begin
                if (i_stat.fin_ok) begin
                    o_op    = OP_ISTART;
                    n_state = ST_IRD;
                end else begin
                    o_op    = OP_BCLR;
                    n_state = ST_IDLE;
                end
            end
            ST_IRD: begin
                if (i_stat.ptr_zero) begin
                    o_op    = OP_IPUT;
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_IRD;
                    n_state = ST_ICMP;
                end
            end
            ST_ICMP: begin
                if (i_stat.row_gt) begin
                    o_op    = OP_ISHIFT;
                    n_state = ST_IRD;
                end else begin
                    o_op    = OP_IPUT;
                    n_state = ST_IDLE;
                end
            end
            ST_CCHK: begin
                if (i_stat.cmd_ok) begin
                    o_op    = OP_CSTART;
                    n_state = ST_CRD;
                end else begin
                    o_op    = OP_BCLR;
                    n_state = ST_IDLE;
                end
            end
            ST_CRD: begin
                if (i_stat.ptr_at_cent) begin
                    o_op    = OP_CPUT;
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_CRD;
                    n_state = ST_CCMP;
                end
            end
            ST_CCMP: begin
                if (i_stat.row_eq) begin
                    o_op    = OP_BCLR;
                    n_state = ST_IDLE;
                end else begin
                    o_op    = OP_CNEXT;
                    n_state = ST_CRD;
                end
            end
            ST_SRD: begin
                if (!i_stat.scan_end) begin
                    o_op    = OP_SRD;
                    n_state = ST_SEV;
                end else if (i_stat.can_retry || i_stat.can_fallback) begin
                    o_op = OP_RETRY;
                end else begin
                    o_op    = OP_BELL;
                    n_state = ST_IDLE;
                end
            end
            ST_SEV: begin
                o_op    = OP_SEV;
                n_state = i_stat.hit_now ? ST_ROOM : ST_SRD;
            end
            ST_ROOM: begin
                if (i_stat.no_room) begin
                    o_op    = OP_BELL;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_op = OP_EMIT;
                if (i_stat.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

[design/name_table_prefix_completion_unit.sv]
// name_table_prefix_completion_unit: top level, file and command name
// tables with prefix completion. Depends on ntpc_pkg, ntpc_ctrl, ntpc_dp.
//
// Usage: drive i_mode and the item fields and raise start; the beat is
// taken on a clock edge with start high and busy low. Loading a char,
// clearing the file table, beginning a query and adding a prefix char
// leave busy low. A file name's last char adds a sorted insertion that
// walks the table (up to 64 entries) downward, reading and shifting each
// displaced entry; a command name's last char adds a duplicate scan of
// each stored entry. A tab scans the selected table, one entry read at a
// time through the single read port of each table RAM, up to three passes
// (retry from the first match, then command fallback), then sends its
// results on consecutive cycles.
// Each result beat is shown for one cycle with o_valid high; the receiver
// cannot stall and must take every beat. The last beat of a tab has
// o_final_res set; a bell beat has o_kind set and ends the session.
// Reset empties both tables and the prefix and ends any session;
// table contents are not cleared, only their counts.
module name_table_prefix_completion_unit import ntpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    input  logic       i_is_directory,
    input  logic       i_first_word,
    input  logic [6:0] i_room,
    output logic       o_valid,
    output logic       o_kind,
    output logic [7:0] o_out_symbol,
    output logic       o_final_res
);

    t_op   s_op;
    t_stat s_stat;

    ntpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_last  (i_last),
        .i_stat  (s_stat),
        .o_op    (s_op),
        .busy    (busy)
    );

    ntpc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (s_op),
        .i_mode         (i_mode),
        .i_symbol       (i_symbol),
        .i_is_directory (i_is_directory),
        .i_first_word   (i_first_word),
        .i_room         (i_room),
        .o_stat         (s_stat),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_out_symbol   (o_out_symbol),
        .o_final_res    (o_final_res)
    );

endmodule
